/* rtl/rid_pkg.sv */
// Shared constants, codes and types of the recycling id allocator.
`default_nettype none

package rid_pkg;

  // Sizes of the id space and of one allocate batch
  localparam int MAX_IDS   = 1024;
  localparam int MAX_BATCH = 64;
  localparam int ID_W      = $clog2(MAX_IDS);
  localparam int CNT_W     = $clog2(MAX_IDS + 1);
  localparam int BATCH_W   = 7;

  // Stream payload widths, packed and padded to whole bytes
  localparam int IN_BITS   = 2 + ID_W + BATCH_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = ID_W + 2 + 2 * CNT_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes; any other code acts as a query
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FIFO_RD,
    ST_LOOKUP
  } state_t;

  // Access to the active-flag memory
  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    logic            wr_data;
  } map_req_t;

  // Access to the free-id FIFO memory
  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    logic [ID_W-1:0] wr_data;
  } fifo_req_t;

endpackage

`default_nettype wire

/* rtl/recycling_id_allocator_core.sv */
// Top level of the recycling id allocator: stream ports, memories and sequencer.
//
// Usage: each input transaction on s_* is one command: allocate a batch of
// ids, remove an id, or query whether an id is active. Results leave on m_*,
// one per requested id (up to 64) for an allocate, one otherwise; m_tlast
// marks the final result of a command. A zero-count allocate gives none.
// Timing: a remove or query reads the active flag in the lookup state, then
// its result goes into the output register. An allocate gives one result per
// cycle for fresh ids while m_tready is high; a recycled id first passes a
// FIFO read state, since it needs a read of the free-id FIFO memory before
// its active flag is written. One command is worked at a time; s_tready is
// high only between commands.
// Reset: all ids inactive, FIFO empty, counters zero. The active-flag memory
// needs no clearing pass: ids at or above the fresh counter read as inactive.
// Stall: while m_tready is low the finished result is held in the output
// register and the sequencer waits before producing the next one.
`default_nettype none

module recycling_id_allocator_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // s_tdata, low bit up: op[1:0], target_id[9:0], alloc_count[6:0], zero pad
  input  wire logic [rid_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // m_tdata, low bit up: given_id[9:0], ok, was_active, live_count[10:0],
  // high_water[10:0], zero pad
  output logic [rid_pkg::OUT_W-1:0]      m_tdata,
  output logic                           m_tlast
);

  rid_pkg::map_req_t          map_req;
  rid_pkg::fifo_req_t         fifo_req;
  logic                       map_rd_data;
  logic [rid_pkg::ID_W-1:0]   fifo_rd_data;
  logic [rid_pkg::ID_W-1:0]   given_id;
  logic                       ok;
  logic                       was_active;
  logic [rid_pkg::CNT_W-1:0]  live_count;
  logic [rid_pkg::CNT_W-1:0]  high_water;

  // Active flag per id
  rid_ram #(
    .WIDTH (1),
    .DEPTH (rid_pkg::MAX_IDS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_req.wr_en),
    .wr_addr (map_req.wr_addr),
    .wr_data (map_req.wr_data),
    .rd_en   (map_req.rd_en),
    .rd_addr (map_req.rd_addr),
    .rd_data (map_rd_data)
  );

  // Ring of freed ids
  rid_ram #(
    .WIDTH (rid_pkg::ID_W),
    .DEPTH (rid_pkg::MAX_IDS)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_req.wr_en),
    .wr_addr (fifo_req.wr_addr),
    .wr_data (fifo_req.wr_data),
    .rd_en   (fifo_req.rd_en),
    .rd_addr (fifo_req.rd_addr),
    .rd_data (fifo_rd_data)
  );

  rid_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_op          (s_tdata[1:0]),
    .in_target_id   (s_tdata[rid_pkg::ID_W+1:2]),
    .in_alloc_count (s_tdata[rid_pkg::ID_W+rid_pkg::BATCH_W+1:rid_pkg::ID_W+2]),
    .map_req        (map_req),
    .map_rd_data    (map_rd_data),
    .fifo_req       (fifo_req),
    .fifo_rd_data   (fifo_rd_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_given_id   (given_id),
    .out_ok         (ok),
    .out_was_active (was_active),
    .out_live_count (live_count),
    .out_high_water (high_water),
    .out_last       (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = rid_pkg::OUT_W'({high_water, live_count, was_active, ok, given_id});

endmodule

`default_nettype wire

/* rtl/rid_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rid_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rid_ctrl.sv */
// Sequencer of the id allocator: FIFO pointers, counters and the result register.
`default_nettype none

module rid_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Input stream fields
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_op,
  input  wire logic [rid_pkg::ID_W-1:0]  in_target_id,
  input  wire logic [rid_pkg::BATCH_W-1:0] in_alloc_count,
  // Memory accesses
  output rid_pkg::map_req_t              map_req,
  input  wire logic                      map_rd_data,
  output rid_pkg::fifo_req_t             fifo_req,
  input  wire logic [rid_pkg::ID_W-1:0]  fifo_rd_data,
  // Result register
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [rid_pkg::ID_W-1:0]       out_given_id,
  output logic                           out_ok,
  output logic                           out_was_active,
  output logic [rid_pkg::CNT_W-1:0]      out_live_count,
  output logic [rid_pkg::CNT_W-1:0]      out_high_water,
  output logic                           out_last
);

  localparam logic [rid_pkg::ID_W-1:0]    ID_TOP    = rid_pkg::ID_W'(rid_pkg::MAX_IDS - 1);
  localparam logic [rid_pkg::CNT_W-1:0]   ID_LIMIT  = rid_pkg::CNT_W'(rid_pkg::MAX_IDS);
  localparam logic [rid_pkg::BATCH_W-1:0] BATCH_CAP = rid_pkg::BATCH_W'(rid_pkg::MAX_BATCH);

  rid_pkg::state_t state, state_next;
  logic                        is_remove, is_remove_next;
  logic [rid_pkg::ID_W-1:0]    tid, tid_next;
  logic [rid_pkg::BATCH_W-1:0] cnt_left, cnt_left_next;
  logic [rid_pkg::ID_W-1:0]    head, head_next;
  logic [rid_pkg::ID_W-1:0]    tail, tail_next;
  logic [rid_pkg::CNT_W-1:0]   fill, fill_next;
  logic [rid_pkg::CNT_W-1:0]   fresh, fresh_next;
  logic [rid_pkg::CNT_W-1:0]   live, live_next;

  logic                        out_free;
  logic                        emit;
  logic [rid_pkg::ID_W-1:0]    emit_id;
  logic                        emit_ok;
  logic                        emit_was;
  logic                        emit_last;
  logic                        was;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == rid_pkg::ST_IDLE);

  // Ids at or above the fresh counter were never handed out, so read as inactive
  assign was = map_rd_data && ({1'b0, tid} < fresh);

  // Next state, memory accesses and counter updates
  always_comb begin
    state_next     = state;
    is_remove_next = is_remove;
    tid_next       = tid;
    cnt_left_next  = cnt_left;
    head_next      = head;
    tail_next      = tail;
    fill_next      = fill;
    fresh_next     = fresh;
    live_next      = live;
    map_req        = '0;
    fifo_req       = '0;
    emit           = 1'b0;
    emit_id        = '0;
    emit_ok        = 1'b0;
    emit_was       = 1'b0;
    emit_last      = 1'b0;

    case (state)
      rid_pkg::ST_IDLE: begin
        if (in_valid) begin
          is_remove_next = (in_op == rid_pkg::OP_REMOVE);
          tid_next       = in_target_id;
          cnt_left_next  = (in_alloc_count > BATCH_CAP) ? BATCH_CAP : in_alloc_count;
          if (in_op == rid_pkg::OP_ALLOC) begin
            // A zero count yields no result
            if (in_alloc_count != '0) begin
              state_next = rid_pkg::ST_ALLOC;
            end
          end else begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = in_target_id;
            state_next      = rid_pkg::ST_LOOKUP;
          end
        end
      end

      rid_pkg::ST_ALLOC: begin
        if (fill != '0) begin
          // Pop a recycled id; it arrives next cycle
          fifo_req.rd_en   = 1'b1;
          fifo_req.rd_addr = head;
          head_next        = (head == ID_TOP) ? '0 : head + 1'b1;
          fill_next        = fill - 1'b1;
          state_next       = rid_pkg::ST_FIFO_RD;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_last = (cnt_left == rid_pkg::BATCH_W'(1));
          if (fresh < ID_LIMIT) begin
            emit_id         = fresh[rid_pkg::ID_W-1:0];
            emit_ok         = 1'b1;
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = fresh[rid_pkg::ID_W-1:0];
            map_req.wr_data = 1'b1;
            fresh_next      = fresh + 1'b1;
            live_next       = live + 1'b1;
          end
          cnt_left_next = cnt_left - 1'b1;
          if (emit_last) begin
            state_next = rid_pkg::ST_IDLE;
          end
        end
      end

      rid_pkg::ST_FIFO_RD: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_id         = fifo_rd_data;
          emit_ok         = 1'b1;
          emit_last       = (cnt_left == rid_pkg::BATCH_W'(1));
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = fifo_rd_data;
          map_req.wr_data = 1'b1;
          live_next       = live + 1'b1;
          cnt_left_next   = cnt_left - 1'b1;
          state_next      = emit_last ? rid_pkg::ST_IDLE : rid_pkg::ST_ALLOC;
        end
      end

      rid_pkg::ST_LOOKUP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_id   = tid;
          emit_was  = was;
          emit_last = 1'b1;
          // Release an active id: clear its flag and push it for reuse
          if (is_remove && was) begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = tid;
            map_req.wr_data = 1'b0;
            if (fill < ID_LIMIT) begin
              fifo_req.wr_en   = 1'b1;
              fifo_req.wr_addr = tail;
              fifo_req.wr_data = tid;
              tail_next        = (tail == ID_TOP) ? '0 : tail + 1'b1;
              fill_next        = fill + 1'b1;
            end
            if (live != '0) begin
              live_next = live - 1'b1;
            end
          end
          state_next = rid_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rid_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rid_pkg::ST_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      fresh     <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
      fresh <= fresh_next;
      live  <= live_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item context and result payload
  always_ff @(posedge clk) begin
    is_remove <= is_remove_next;
    tid       <= tid_next;
    cnt_left  <= cnt_left_next;
    if (emit) begin
      out_given_id   <= emit_id;
      out_ok         <= emit_ok;
      out_was_active <= emit_was;
      out_live_count <= live_next;
      out_high_water <= fresh_next;
      out_last       <= emit_last;
    end
  end

endmodule

`default_nettype wire
